// ===== rtl/core/fadd_pkg.sv =====
package fadd_pkg;

   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [31:0] NEG_ZERO  = 32'h8000_0000;
   localparam logic [7:0]  EXP_MAX   = 8'd255;
   localparam logic [7:0]  EXP_TOP   = 8'd254;
   localparam logic [7:0]  MAX_GAP   = 8'd25;

   // Operands after the magnitude swap: w is the larger one.
   typedef struct packed {
      logic [31:0] w;
      logic [31:0] l;
   } pair_type;

endpackage

// ===== rtl/core/float32_adder_flush_to_zero.sv =====
// Throughput: one word per cycle; the input register, the adder logic and the
// result register form a two-stage pipeline with stall on rsp_tready.
// Reset: synchronous, active high; clears the valid flags, payload untouched.
module float32_adder_flush_to_zero (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // operand_a [31:0], operand_b [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // sum_bits [31:0]
);

   logic               in_vld_ff, out_vld_ff;
   fadd_pkg::pair_type pair_ff, pair_in;
   logic [31:0]        sum_ff, sum_in;
   logic               adv_out, adv_in;

   // Pipeline moves whenever the next stage is free.
   assign adv_out    = !out_vld_ff || rsp_tready;
   assign adv_in     = !in_vld_ff || adv_out;
   assign req_tready = adv_in;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = sum_ff;

   // Order operands by magnitude ignoring sign; ties keep operand_a larger.
   always_comb begin
      if (req_tdata[30:0] >= req_tdata[62:32]) begin
         pair_in.w = req_tdata[31:0];
         pair_in.l = req_tdata[63:32];
      end else begin
         pair_in.w = req_tdata[63:32];
         pair_in.l = req_tdata[31:0];
      end
   end

   fadd_calc u_calc (
      .op       (pair_ff),
      .sum_bits (sum_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (adv_in) in_vld_ff <= req_tvalid;
         if (adv_out) out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in) pair_ff <= pair_in;
      if (adv_out) sum_ff <= sum_in;
   end

endmodule

// ===== rtl/core/fadd_calc.sv =====
// Combinational sum of an ordered operand pair.
module fadd_calc (
   input  fadd_pkg::pair_type op,
   output logic [31:0]        sum_bits
);

   logic        ws, ls;
   logic [7:0]  we, le, gap, cnt;
   logic [23:0] wm, lm;
   logic [25:0] al2, al1;
   logic [26:0] al1_full, al2_full;
   logic        st1, st2;
   logic [25:0] ts, tsr;
   logic [25:0] td;
   logic [25:0] tn, tl;
   logic [24:0] fr;
   logic [31:0] res;
   logic [7:0]  expo;
   logic [24:0] frac;

   always_comb begin
      ws  = op.w[31];
      ls  = op.l[31];
      we  = op.w[30:23];
      le  = op.l[30:23];
      wm  = {1'b1, op.w[22:0]};
      lm  = {1'b1, op.l[22:0]};
      gap = we - le;

      // Aligned smaller significand, with one and two extra low bits.
      al1_full = {2'b00, lm, 1'b0} >> gap[4:0];
      al2_full = {1'b0, lm, 2'b00} >> gap[4:0];
      al1 = al1_full[25:0];
      al2 = al2_full[25:0];
      st1 = (({2'b00, lm, 1'b0} & ((27'd1 << gap[4:0]) - 27'd1)) != 27'd0);
      st2 = (({1'b0, lm, 2'b00} & ((27'd1 << gap[4:0]) - 27'd1)) != 27'd0);

      ts  = {1'b0, wm, 1'b0} + al1;
      tsr = ts;
      td  = {wm, 2'b00} - al2;
      tn  = '0;
      tl  = '0;
      fr  = '0;
      cnt = '0;
      expo = we;
      frac = '0;
      res  = '0;

      // A carry out of the rounded fraction spills into the exponent's low bit.
      if (we == fadd_pkg::EXP_MAX) begin
         res = (le == fadd_pkg::EXP_MAX && ws != ls) ? fadd_pkg::CANON_NAN : op.w;
      end else if (le == 8'd0) begin
         if (we == 8'd0) res = (ws && ls) ? fadd_pkg::NEG_ZERO : 32'd0;
         else res = op.w;
      end else if (gap > fadd_pkg::MAX_GAP) begin
         res = op.w;
      end else begin
         if (ws == ls) begin
            // Same sign: add and round.
            if (ts[25]) begin
               frac = {1'b0, ts[25:2]} - 25'h80_0000;
               if (ts[1] && (ts[0] || ts[2] || st1)) frac = frac + 25'd1;
               expo = we + 8'd1;
            end else begin
               if (ts[0] && (ts[1] || st1)) tsr = ts + 26'd1;
               if (tsr[25]) begin
                  frac = {1'b0, tsr[25:2]} - 25'h80_0000;
                  expo = we + 8'd1;
               end else begin
                  frac = tsr[25:1] - 25'h80_0000;
                  expo = we;
               end
            end
            if (ts[25] && we == fadd_pkg::EXP_TOP)
               res = {ws, 8'hFF, 23'd0};
            else
               res = {ws, expo, 23'd0} | {8'd0, frac[23:0]};
         end else if (gap > 8'd1) begin
            // Far subtract: at most one position of normalization.
            if (td[25]) begin
               expo = we;
               frac = {1'b0, td[25:2]} - 25'h80_0000;
               if (td[1:0] == 2'b11 || (td[2:0] == 3'b110 && !st2))
                  frac = frac + 25'd1;
            end else begin
               fr = td[25:1];
               if (td[1:0] == 2'b11 && !st2) fr = fr + 25'd1;
               if (fr[24]) begin
                  frac = {1'b0, fr[24:1]} - 25'h80_0000;
                  expo = we;
               end else begin
                  frac = fr - 25'h80_0000;
                  expo = we - 8'd1;
               end
            end
            res = {ws, expo, 23'd0} | {8'd0, frac[23:0]};
         end else begin
            // Near subtract: gap 0 or 1, leading-zero normalization.
            tn = gap[0] ? ({1'b0, wm, 1'b0} - {2'b00, lm})
                        : ({2'b00, wm} - {2'b00, lm});
            for (int i = 0; i < 26; i++) begin
               if (tn[i]) cnt = 8'(gap[0] ? (24 - i) : (23 - i));
            end
            tl = tn << cnt[4:0];
            if (tn == 26'd0 || we < cnt + 8'd1) begin
               res = 32'd0;
            end else begin
               expo = we - cnt;
               if (cnt == 8'd0 && tl[1:0] == 2'b11)
                  frac = tl[25:1] + 25'd1 - 25'h80_0000;
               else
                  frac = (gap[0] ? tl[25:1] : tl[24:0]) - 25'h80_0000;
               res = {ws, expo, 23'd0} | {8'd0, frac[23:0]};
            end
         end
      end
      sum_bits = res;
   end

endmodule
